@@ hdl/stereo_ring_trigger_search_defines.svh @@
// Assertion macros used by the checker file of the stereo ring trigger search.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef STEREO_RING_TRIGGER_SEARCH_DEFINES_SVH
`define STEREO_RING_TRIGGER_SEARCH_DEFINES_SVH

// Overlapping implication, disabled while reset is asserted.
`define SRTS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srts: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srts: next-cycle implication failed");

`endif

@@ hdl/srts_pkg.sv @@
// Shared constants and types of the stereo ring trigger search.
// Used by the memory, the scan sequencer, the top level and the checker.
package srts_pkg;

    localparam int DEPTH_DEF       = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FIELD_BITS      = 16;
    localparam int POS_BITS        = 10;
    localparam int OP_BITS         = 2;
    localparam int IN_TDATA_BITS   = 48;
    localparam int OUT_TDATA_BITS  = 16;

    localparam logic [OP_BITS-1:0] OP_PUSH       = 2'd0;
    localparam logic [OP_BITS-1:0] OP_FIND_LEFT  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FIND_RIGHT = 2'd2;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    typedef struct packed {
        logic [POS_BITS-1:0] position;
        logic                found;
    } t_res;

endpackage

@@ hdl/stereo_ring_trigger_search.sv @@
// Stereo ring buffer with a level-trigger search, for an oscilloscope view.
// Depends on srts_pkg, srts_ring_mem and srts_scan.
//
// Input channel (s_axis): tuser carries the opcode (push, search left, search
// right); tdata carries the left sample, the right sample and the level.
// A push writes both samples at the write pointer and advances it; while no
// search runs, pushes stream at one transaction per cycle and give no result.
// A search walks the chosen channel in ring order from the entry after the
// write pointer, one memory read per cycle, and returns one result transaction
// on m_axis: the first index whose earlier neighbor is at or below the level
// and whose later neighbor is at or above it, or the write pointer with found
// clear. Input is held off from the search until its result is in the output
// register. The output register holds a result while the receiver stalls;
// while no search runs, pushes are still taken then; a next search runs, but
// its result waits in the sequencer, holding input off, until the register
// frees up.
// Reset clears the pointer and the handshake state at once; entries not yet
// written since reset read as zero, so no clearing pass is needed.
// Opcode 3 is accepted and ignored.
module stereo_ring_trigger_search #(
    parameter int DEPTH       = srts_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = srts_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [15:0] left_sample, [31:16] right_sample, [47:32] level
    input  logic [srts_pkg::IN_TDATA_BITS-1:0]   i_s_axis_tdata,
    // [1:0] opcode
    input  logic [srts_pkg::OP_BITS-1:0]         i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [9:0] position, [15:10] zero
    output logic [srts_pkg::OUT_TDATA_BITS-1:0]  o_m_axis_tdata,
    // [0] found
    output logic                                 o_m_axis_tuser
);
    import srts_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    logic [PW-1:0]                 r_wp;
    logic                          r_wrapped;
    logic                          r_ovalid;
    t_res                          r_out;

    logic                          w_accept;
    logic                          w_push;
    logic                          w_find;
    logic                          w_busy;
    logic signed [FIELD_BITS-1:0]  w_left_in;
    logic signed [FIELD_BITS-1:0]  w_right_in;
    logic signed [FIELD_BITS-1:0]  w_level_in;
    logic signed [SAMPLE_BITS-1:0] w_left;
    logic signed [SAMPLE_BITS-1:0] w_right;
    logic signed [SAMPLE_BITS-1:0] w_level;
    logic                          w_re;
    logic [PW-1:0]                 w_raddr;
    logic signed [SAMPLE_BITS-1:0] w_rdata_l;
    logic signed [SAMPLE_BITS-1:0] w_rdata_r;
    t_mem_ctl                      w_ctl;
    logic                          w_res_valid;
    logic                          w_res_take;
    t_res                          w_res;

    assign o_s_axis_tready = !w_busy;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_push          = w_accept && (i_s_axis_tuser == OP_PUSH);
    assign w_find          = w_accept && ((i_s_axis_tuser == OP_FIND_LEFT)
                                          || (i_s_axis_tuser == OP_FIND_RIGHT));

    assign w_left_in  = i_s_axis_tdata[FIELD_BITS-1:0];
    assign w_right_in = i_s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS];
    assign w_level_in = i_s_axis_tdata[3*FIELD_BITS-1:2*FIELD_BITS];
    // A signed size cast sign-extends to wider samples and keeps the low bits
    // of narrower ones.
    assign w_left     = SAMPLE_BITS'(w_left_in);
    assign w_right    = SAMPLE_BITS'(w_right_in);
    assign w_level    = SAMPLE_BITS'(w_level_in);

    assign w_ctl.we = w_push;
    assign w_ctl.re = w_re;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else if (w_push) begin
            if (r_wp == LAST_IDX) begin
                r_wp      <= '0;
                r_wrapped <= 1'b1;
            end else begin
                r_wp <= r_wp + 1'b1;
            end
        end
    end

    srts_ring_mem #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_waddr   (r_wp),
        .i_wdata_l (w_left),
        .i_wdata_r (w_right),
        .i_raddr   (w_raddr),
        .o_rdata_l (w_rdata_l),
        .o_rdata_r (w_rdata_r)
    );

    srts_scan #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_find),
        .i_chan_right (i_s_axis_tuser == OP_FIND_RIGHT),
        .i_level      (w_level),
        .i_wp         (r_wp),
        .i_wrapped    (r_wrapped),
        .o_re         (w_re),
        .o_raddr      (w_raddr),
        .i_rdata_l    (w_rdata_l),
        .i_rdata_r    (w_rdata_r),
        .o_busy       (w_busy),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_take),
        .o_res        (w_res)
    );

    assign w_res_take = w_res_valid && (!r_ovalid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res_take) begin
            r_ovalid <= 1'b1;
            r_out    <= w_res;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OUT_TDATA_BITS'(r_out.position);
    assign o_m_axis_tuser  = r_out.found;

endmodule

@@ hdl/srts_ring_mem.sv @@
// Two channel sample memories sharing one write port and one registered read port.
// Depends on srts_pkg for the control struct.
module srts_ring_mem #(
    parameter int DEPTH       = srts_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = srts_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  srts_pkg::t_mem_ctl             i_ctl,
    input  logic [$clog2(DEPTH)-1:0]       i_waddr,
    input  logic signed [SAMPLE_BITS-1:0]  i_wdata_l,
    input  logic signed [SAMPLE_BITS-1:0]  i_wdata_r,
    input  logic [$clog2(DEPTH)-1:0]       i_raddr,
    output logic signed [SAMPLE_BITS-1:0]  o_rdata_l,
    output logic signed [SAMPLE_BITS-1:0]  o_rdata_r
);
    import srts_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_left_mem  [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_right_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_left_mem[i_waddr]  <= i_wdata_l;
            r_right_mem[i_waddr] <= i_wdata_r;
        end
        if (i_ctl.re) begin
            o_rdata_l <= r_left_mem[i_raddr];
            o_rdata_r <= r_right_mem[i_raddr];
        end
    end

endmodule

@@ hdl/srts_scan.sv @@
// Search sequencer: walks the ring through the memory read port and keeps a
// three-sample window for the level-crossing test. Depends on srts_pkg.
module srts_scan #(
    parameter int DEPTH       = srts_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = srts_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_chan_right,
    input  logic signed [SAMPLE_BITS-1:0]  i_level,
    input  logic [$clog2(DEPTH)-1:0]       i_wp,
    input  logic                           i_wrapped,
    output logic                           o_re,
    output logic [$clog2(DEPTH)-1:0]       o_raddr,
    input  logic signed [SAMPLE_BITS-1:0]  i_rdata_l,
    input  logic signed [SAMPLE_BITS-1:0]  i_rdata_r,
    output logic                           o_busy,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output srts_pkg::t_res                 o_res
);
    import srts_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 3);
    // One read before and one after the DEPTH candidate positions.
    localparam logic [CW-1:0] ISSUE_END = CW'(DEPTH + 2);
    localparam logic [CW-1:0] LAST_K    = CW'(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX  = PW'(DEPTH - 1);
    localparam logic [1:0]    WIN_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    t_state                        r_state;
    logic [PW-1:0]                 r_raddr;
    logic [CW-1:0]                 r_issued;
    logic                          r_chan_right;
    logic signed [SAMPLE_BITS-1:0] r_level;
    logic                          r_rv;
    logic                          r_rv_last;
    logic                          r_rv_wr;
    logic [PW-1:0]                 r_rv_addr;
    logic [1:0]                    r_fill;
    logic signed [SAMPLE_BITS-1:0] r_w0;
    logic signed [SAMPLE_BITS-1:0] r_w1;
    logic [PW-1:0]                 r_mid;
    t_res                          r_res;

    logic                          w_issue;
    logic                          w_written;
    logic [PW-1:0]                 w_raddr_inc;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic                          w_hit;

    assign w_issue     = (r_state == S_RUN) && (r_issued != ISSUE_END);
    // Entries are filled in ring order from zero, so the pointer and the wrap
    // flag tell which ones have not been written since reset; those read as zero.
    assign w_written   = i_wrapped || (r_raddr < i_wp);
    assign w_raddr_inc = (r_raddr == LAST_IDX) ? '0 : r_raddr + 1'b1;
    assign w_sample    = !r_rv_wr ? '0 : (r_chan_right ? i_rdata_r : i_rdata_l);
    assign w_hit       = r_rv && (r_fill == WIN_FULL) && (r_w0 <= r_level)
                         && (w_sample >= r_level);

    assign o_re        = w_issue;
    assign o_raddr     = r_raddr;
    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_HOLD);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_rv <= 1'b0;
                    if (i_start) begin
                        r_state      <= S_RUN;
                        r_raddr      <= i_wp;
                        r_issued     <= '0;
                        r_fill       <= '0;
                        r_chan_right <= i_chan_right;
                        r_level      <= i_level;
                    end
                end
                S_RUN: begin
                    // A late read valid after the result is ignored in the hold state.
                    r_rv      <= w_issue;
                    r_rv_last <= w_issue && (r_issued == LAST_K);
                    r_rv_wr   <= w_written;
                    r_rv_addr <= r_raddr;
                    if (w_issue) begin
                        r_raddr  <= w_raddr_inc;
                        r_issued <= r_issued + 1'b1;
                    end
                    if (r_rv) begin
                        r_w0  <= r_w1;
                        r_w1  <= w_sample;
                        r_mid <= r_rv_addr;
                        if (r_fill != WIN_FULL) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        if (w_hit) begin
                            r_state        <= S_HOLD;
                            r_res.position <= POS_BITS'(r_mid);
                            r_res.found    <= 1'b1;
                        end else if (r_rv_last) begin
                            r_state        <= S_HOLD;
                            r_res.position <= POS_BITS'(i_wp);
                            r_res.found    <= 1'b0;
                        end
                    end
                end
                S_HOLD: begin
                    r_rv <= 1'b0;
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/srts_checker.sv @@
// Port-level checks of the stereo ring trigger search, bound to its top level.
// Depends on srts_pkg and the assertion macros in the defines header.
`include "stereo_ring_trigger_search_defines.svh"

module srts_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_s_axis_tvalid,
    input logic                                 o_s_axis_tready,
    input logic [srts_pkg::OP_BITS-1:0]         i_s_axis_tuser,
    input logic                                 o_m_axis_tvalid,
    input logic                                 i_m_axis_tready,
    input logic [srts_pkg::OUT_TDATA_BITS-1:0]  o_m_axis_tdata,
    input logic                                 o_m_axis_tuser
);
    import srts_pkg::*;

    logic w_in_acc;
    logic w_push_acc;
    logic w_find_acc;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_push_acc = w_in_acc && (i_s_axis_tuser == OP_PUSH);
    assign w_find_acc = w_in_acc && ((i_s_axis_tuser == OP_FIND_LEFT)
                                     || (i_s_axis_tuser == OP_FIND_RIGHT));

    // A stalled result transaction keeps its contents.
    `SRTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // An accepted search keeps the sequencer busy, so input stays held off after it.
    `SRTS_ASSERT_NEXT(a_find_busy, i_clk, i_rst_n, w_find_acc, !o_s_axis_tready)

    // A push on an idle block never brings up a result.
    `SRTS_ASSERT_NEXT(a_push_quiet, i_clk, i_rst_n, w_push_acc && !o_m_axis_tvalid, !o_m_axis_tvalid)

    // While input is ready, no search is pending, so no new result may appear.
    `SRTS_ASSERT_IMPLY(a_ready_no_rise, i_clk, i_rst_n, o_s_axis_tready && !$past(o_m_axis_tvalid) && $past(o_s_axis_tready), !o_m_axis_tvalid)

endmodule

bind stereo_ring_trigger_search srts_checker u_srts_checker (.*);
